// ===== hw/rtl/rgb_sharpen_3x3_convolution_unit_macros.svh =====
// Assertion macros shared by the sharpen filter RTL.
// Each macro checks at the rising edge of clk, with checking held off while rstn is low.
// Define ASSERT_OFF to compile all of them away.
`ifndef RGB_SHARPEN_3X3_CONVOLUTION_UNIT_MACROS_SVH
`define RGB_SHARPEN_3X3_CONVOLUTION_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define RSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RSC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/rsc_pkg.sv =====
`default_nettype none

package rsc_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_index_t;

    // Taps of the 3x3 window that the cross-shaped kernel touches
    typedef struct packed {
        pixel_t up;
        pixel_t left;
        pixel_t center;
        pixel_t right;
        pixel_t down;
    } win_taps_t;

    // Per-item position results, worked out when the item is taken in
    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } pos_flags_t;

    localparam logic [11:0] WIDTH_RESET  = 12'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;
    localparam logic [11:0] MIN_DIM      = 12'd3;
    localparam logic [11:0] ROW_MAX      = 12'd4095;
    localparam logic [7:0]  CHAN_MAX     = 8'd255;
    localparam logic [7:0]  CHAN_MIN     = 8'd0;

endpackage

`default_nettype wire

// ===== hw/rtl/rsc_line_buf.sv =====
`default_nettype none

module rsc_line_buf #(
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire rsc_pkg::pixel_t          wr_pixel,
    output rsc_pkg::pixel_t               upper_q,
    output rsc_pkg::pixel_t               middle_q
);

    localparam int AW = $clog2(DEPTH);

    rsc_pkg::pixel_t upper_mem  [DEPTH];
    rsc_pkg::pixel_t middle_mem [DEPTH];

    rsc_pkg::pixel_t upper_q_reg;
    rsc_pkg::pixel_t middle_q_reg;
    logic [AW-1:0]   wr_addr_reg;
    logic            wr_pend_reg;
    logic            wr_pend_next;

    assign wr_pend_next = rd_en;

    // Middle line: read old entry and store the new pixel in the same edge
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            middle_q_reg     <= middle_mem[addr];
            middle_mem[addr] <= wr_pixel;
            wr_addr_reg      <= addr;
        end
    end

    // Upper line takes the old middle entry in the following cycle, once it has been read out
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_q_reg <= upper_mem[addr];
        end
        if (wr_pend_reg) begin
            upper_mem[wr_addr_reg] <= middle_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= wr_pend_next;
        end
    end

    assign upper_q  = upper_q_reg;
    assign middle_q = middle_q_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_pixel_cell.sv =====
`default_nettype none

// One window element: loads the pixel on pix_in on each shift and holds it otherwise
module rsc_pixel_cell (
    input  wire logic            aclk,
    input  wire logic            shift_en,
    input  wire rsc_pkg::pixel_t pix_in,
    output rsc_pkg::pixel_t      pix_out
);

    rsc_pkg::pixel_t pix_reg;
    rsc_pkg::pixel_t pix_next;

    assign pix_next = shift_en ? pix_in : pix_reg;

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

    assign pix_out = pix_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rsc_sharpen.sv =====
`default_nettype none

module rsc_sharpen (
    input  wire rsc_pkg::win_taps_t taps,
    input  wire logic               border,
    output rsc_pkg::pixel_t         pix_out
);

    // 9*c - up - left - right - down, clamped to 0..255
    function automatic logic [7:0] sharpen_chan(
        input logic [7:0] c,
        input logic [7:0] u,
        input logic [7:0] l,
        input logic [7:0] r,
        input logic [7:0] d
    );
        logic signed [12:0] s;
        logic [7:0]         res;
        s = $signed({2'b00, c, 3'b000}) + $signed({5'b00000, c})
          - $signed({5'b00000, u}) - $signed({5'b00000, l})
          - $signed({5'b00000, r}) - $signed({5'b00000, d});
        if (s[12]) begin
            res = rsc_pkg::CHAN_MIN;
        end else if (s > $signed({5'b00000, rsc_pkg::CHAN_MAX})) begin
            res = rsc_pkg::CHAN_MAX;
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

    rsc_pkg::pixel_t filt;

    always_comb begin
        filt.red   = sharpen_chan(taps.center.red, taps.up.red, taps.left.red,
                                  taps.right.red, taps.down.red);
        filt.green = sharpen_chan(taps.center.green, taps.up.green, taps.left.green,
                                  taps.right.green, taps.down.green);
        filt.blue  = sharpen_chan(taps.center.blue, taps.up.blue, taps.left.blue,
                                  taps.right.blue, taps.down.blue);
    end

    assign pix_out = border ? taps.center : filt;

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_sharpen_3x3_convolution_unit.sv =====
// 3x3 sharpen filter for a raster-order RGB stream, one pixel per clock sustained while
// m_ready stays high. Each channel is convolved with {0,-1,0; -1,9,-1; 0,-1,0} and
// clamped to 0..255; border pixels pass through unchanged. An accepted item is held in
// stage A, then any result in the m_ side output register. The rate is set by the two
// line stores (MAX_WIDTH x 24 bits each), which take one read and one write per pixel.
// Results lag the input by one row plus one pixel: after the last pixel of a frame,
// send frame_width+1 items with s_op = 1 (flush) to drain it. m_frame_end marks the
// bottom-right pixel, and all position counters then restart. The line stores need no
// clearing after reset. Write frame_width/frame_height only while the block is idle.
`default_nettype none
`include "rgb_sharpen_3x3_convolution_unit_macros.svh"

module rgb_sharpen_3x3_convolution_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [11:0] cfg_wdata,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_pixel_red,
    input  wire logic [7:0]  s_pixel_green,
    input  wire logic [7:0]  s_pixel_blue,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic             m_frame_end
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
    localparam int CMPW = (EW > CW + 1) ? EW : CW + 1;

    // ---------------- configuration ----------------
    logic [11:0] width_reg,  width_next;
    logic [11:0] height_reg, height_next;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (rsc_pkg::reg_index_t'(cfg_index))
                rsc_pkg::REG_FRAME_WIDTH:  width_next  = cfg_wdata;
                rsc_pkg::REG_FRAME_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [EW-1:0] eff_w;
    logic [11:0]   eff_h;

    always_comb begin
        if (EW'(width_reg) < EW'(rsc_pkg::MIN_DIM)) begin
            eff_w = EW'(rsc_pkg::MIN_DIM);
        end else if (EW'(width_reg) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(width_reg);
        end
        eff_h = (height_reg < rsc_pkg::MIN_DIM) ? rsc_pkg::MIN_DIM : height_reg;
    end

    // ---------------- handshake ----------------
    logic a_valid_reg, a_valid_next;
    logic m_valid_reg, m_valid_next;
    logic a_adv;
    logic s_fire;

    assign a_adv   = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !a_valid_reg || a_adv;
    assign s_fire  = s_valid && s_ready;

    // ---------------- position counters ----------------
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [11:0]   in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [11:0]   out_row_reg, out_row_next;

    logic       in_wrap;
    logic       out_col_end;
    logic       out_row_end;
    rsc_pkg::pos_flags_t flags_now;

    assign in_wrap     = (CMPW'(in_col_reg) + CMPW'(1)) >= CMPW'(eff_w);
    assign out_col_end = (CMPW'(out_col_reg) + CMPW'(1)) >= CMPW'(eff_w);
    assign out_row_end = ({1'b0, out_row_reg} + 13'd1) >= {1'b0, eff_h};

    always_comb begin
        flags_now.emit   = (in_row_reg >= 12'd2) || (in_row_reg == 12'd1 && in_col_reg != '0);
        flags_now.border = (out_row_reg == '0) || out_row_end
                        || (out_col_reg == '0) || out_col_end;
        flags_now.last   = out_col_end && out_row_end;
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (s_fire) begin
            if (in_wrap) begin
                in_col_next = '0;
                if (in_row_reg != rsc_pkg::ROW_MAX) begin
                    in_row_next = in_row_reg + 12'd1;
                end
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (flags_now.emit) begin
                if (flags_now.last) begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end else if (out_col_end) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 12'd1;
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    // ---------------- stage A: line store read ----------------
    rsc_pkg::pixel_t     in_px;
    rsc_pkg::pixel_t     a_px_reg;
    rsc_pkg::pos_flags_t a_flags_reg;
    rsc_pkg::pixel_t     upper_q;
    rsc_pkg::pixel_t     middle_q;

    always_comb begin
        if (rsc_pkg::op_t'(s_op) == rsc_pkg::OP_FLUSH) begin
            in_px = '0;
        end else begin
            in_px.red   = s_pixel_red;
            in_px.green = s_pixel_green;
            in_px.blue  = s_pixel_blue;
        end
    end

    assign a_valid_next = s_fire ? 1'b1 : (a_adv ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_px_reg    <= in_px;
            a_flags_reg <= flags_now;
        end
    end

    rsc_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire),
        .addr     (in_col_reg),
        .wr_pixel (in_px),
        .upper_q  (upper_q),
        .middle_q (middle_q)
    );

    // ---------------- window cells ----------------
    // Center column of the window plus the middle of the column left of it
    rsc_pkg::pixel_t up_pix;
    rsc_pkg::pixel_t center_pix;
    rsc_pkg::pixel_t down_pix;
    rsc_pkg::pixel_t left_pix;

    rsc_pixel_cell u_cell_up (
        .aclk     (aclk),
        .shift_en (a_adv),
        .pix_in   (upper_q),
        .pix_out  (up_pix)
    );

    rsc_pixel_cell u_cell_center (
        .aclk     (aclk),
        .shift_en (a_adv),
        .pix_in   (middle_q),
        .pix_out  (center_pix)
    );

    rsc_pixel_cell u_cell_down (
        .aclk     (aclk),
        .shift_en (a_adv),
        .pix_in   (a_px_reg),
        .pix_out  (down_pix)
    );

    rsc_pixel_cell u_cell_left (
        .aclk     (aclk),
        .shift_en (a_adv),
        .pix_in   (center_pix),
        .pix_out  (left_pix)
    );

    // The cells still hold the window before this item's shift, so the new
    // center is the old right column and the new right tap is this item's middle read.
    rsc_pkg::win_taps_t taps;
    rsc_pkg::pixel_t    result_pix;

    always_comb begin
        taps.up     = up_pix;
        taps.left   = left_pix;
        taps.center = center_pix;
        taps.right  = middle_q;
        taps.down   = down_pix;
    end

    rsc_sharpen u_sharpen (
        .taps    (taps),
        .border  (a_flags_reg.border),
        .pix_out (result_pix)
    );

    // ---------------- output register ----------------
    rsc_pkg::pixel_t out_pix_reg;
    logic            out_end_reg;

    always_comb begin
        if (a_adv) begin
            m_valid_next = a_flags_reg.emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && a_flags_reg.emit) begin
            out_pix_reg <= result_pix;
            out_end_reg <= a_flags_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= rsc_pkg::WIDTH_RESET;
            height_reg  <= rsc_pkg::HEIGHT_RESET;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = out_pix_reg.red;
    assign m_out_green = out_pix_reg.green;
    assign m_out_blue  = out_pix_reg.blue;
    assign m_frame_end = out_end_reg;

    // ---------------- assertions ----------------
    `RSC_ASSERT_IMPL(a_last_needs_emit, aclk, aresetn, a_valid_reg && a_flags_reg.last, a_flags_reg.emit, "frame end flagged on an item without result")
    `RSC_ASSERT_IMPL(stall_only_when_full, aclk, aresetn, !s_ready, a_valid_reg && m_valid_reg && !m_ready, "input stalled with room in the pipeline")
    `RSC_ASSERT_NEXT(frame_end_clears_pos, aclk, aresetn, s_fire && flags_now.emit && flags_now.last, in_col_reg == '0 && in_row_reg == '0 && out_col_reg == '0 && out_row_reg == '0, "counters not cleared after frame end")

endmodule

`default_nettype wire
